/* sv/psb_pkg.sv */
// Shared types, constants and helpers for the prime sieve bitmap block.
package psb_pkg;

  localparam int PSB_MAX_NUMBER = 65535;
  localparam int PSB_WORD_COUNT = 1024;

  localparam int NUM_W  = 16;  // number / limit width
  localparam int WIDX_W = 10;  // word index width (NUM_W - 6)
  localparam int DATA_W = 64;  // bitmap word width
  localparam int STS_W  = 2;

  typedef enum logic {
    OP_SIEVE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_SIEVE_DONE = 2'd0,
    STS_READ_OK    = 2'd1,
    STS_RANGE_ERR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_CHECK_RD,
    ST_CHECK,
    ST_CROSS,
    ST_LOAD,
    ST_DONE
  } state_t;

  // Bits of word w that stand for numbers 2..lim.
  function automatic logic [DATA_W-1:0] word_mask(input logic [WIDX_W-1:0] w,
                                                  input logic [NUM_W-1:0]  lim);
    logic [DATA_W-1:0] m;
    begin
      if (w < lim[NUM_W-1:6]) begin
        m = '1;
      end else if (w == lim[NUM_W-1:6]) begin
        m = {DATA_W{1'b1}} >> (6'd63 - lim[5:0]);
      end else begin
        m = '0;
      end
      if (w == '0) begin
        m[1:0] = 2'b00;
      end
      return m;
    end
  endfunction

endpackage

/* sv/psb_req_if.sv */
// Request channel: operation and word index with valid/ready.
interface psb_req_if import psb_pkg::*;;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [WIDX_W-1:0] word_index;

  modport source (output valid, output operation, output word_index, input ready);
  modport sink   (input valid, input operation, input word_index, output ready);
endinterface

/* sv/psb_rsp_if.sv */
// Response channel: prime bits and status with valid/ready.
interface psb_rsp_if import psb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] prime_bits;
  logic [STS_W-1:0]  status;

  modport source (output valid, output prime_bits, output status, input ready);
  modport sink   (input valid, input prime_bits, input status, output ready);
endinterface

/* sv/prime_sieve_bitmap.sv */
// Sieve of Eratosthenes engine over a 64-bit-word bitmap memory.
//
// Channels: req (operation, word_index) and rsp (prime_bits, status), both
// valid/ready; a request moves when valid and ready are high at a clock edge.
// cfg_wr_en/cfg_wr_data write upper_limit; write only while the block is idle.
// A read request returns the bitmap word masked to 2..limit (status 1), or
// zero with status 2 when the word lies beyond the limit.
// Reads: each result is registered in the memory stage, then the output
// register; one read request per cycle is sustained while rsp.ready holds,
// set by the single read port of the bitmap memory. Sieve: fill words
// 0..limit/64, then per candidate i with i*i <= limit read and test its bit;
// for a prime, clear its multiples from 2*i to the limit (read-modify-write
// through a one-word buffer in front of the memory), then end the scan and
// queue the done response. No request is accepted while a sieve runs; the
// done response (status 0) follows all earlier read responses in order.
// Reset: control clears at once; there is no clearing pass. Until the first
// sieve every read returns zero (an epoch flag masks the memory), and words
// above the limit of the last sieve are masked off the same way.
// Receiver stall: a two-entry pipe (memory stage, output register) holds
// results; ready drops only when both are full.
module prime_sieve_bitmap import psb_pkg::*; #(
  parameter int MAX_NUMBER = PSB_MAX_NUMBER,
  parameter int WORD_COUNT = PSB_WORD_COUNT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [NUM_W-1:0] cfg_wr_data,
  psb_req_if.sink          req,
  psb_rsp_if.source        rsp
);

  localparam int          AW      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int          CAP_INT = (MAX_NUMBER < WORD_COUNT * 64 - 1) ?
                                    MAX_NUMBER : WORD_COUNT * 64 - 1;
  localparam logic [31:0] LIM_CAP = CAP_INT;
  localparam logic [31:0] WC32    = WORD_COUNT;

  // Config register and effective limit
  logic [NUM_W-1:0] upper_limit;
  logic [NUM_W-1:0] eff_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= '1;
    end else if (cfg_wr_en) begin
      upper_limit <= cfg_wr_data;
    end
  end

  assign eff_lim = ({16'b0, upper_limit} > LIM_CAP) ? LIM_CAP[NUM_W-1:0] : upper_limit;

  // Bitmap memory, one write and one registered read port
  logic [DATA_W-1:0] mem [WORD_COUNT];
  logic              mem_we, mem_re;
  logic [WIDX_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(mem_waddr)] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[AW'(mem_raddr)];
    end
  end

  // Control and sieve registers
  state_t            state, state_next;
  logic              sieved, sieved_next;
  logic [NUM_W-1:0]  sieve_lim, sieve_lim_next;
  logic [WIDX_W-1:0] fill_w, fill_w_next;
  logic [8:0]        i_num, i_next;
  logic [16:0]       m_num, m_next;
  logic [DATA_W-1:0] buf_word, buf_word_next;
  logic [WIDX_W-1:0] buf_idx, buf_idx_next;
  logic              buf_valid, buf_valid_next;
  logic [17:0]       i_sq;

  // Pipe: s1 waits on memory data, output register feeds rsp
  logic              s1_valid, s1_valid_next;
  status_t           s1_status, s1_status_next;
  logic [DATA_W-1:0] s1_mask, s1_mask_next;
  logic              out_valid;
  status_t           out_status;
  logic [DATA_W-1:0] out_bits;
  logic              s2_free, req_fire, go, range_err;
  logic [NUM_W-1:0]  mask_lim;

  assign s2_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && (!s1_valid || s2_free);
  assign req_fire = req.valid && req.ready;
  assign go       = !s1_valid;     // sieve owns the read port once s1 is empty
  assign i_sq     = {9'b0, i_num} * {9'b0, i_num};
  assign mask_lim = (sieve_lim < eff_lim) ? sieve_lim : eff_lim;
  assign range_err = ({{(32-WIDX_W){1'b0}}, req.word_index} >= WC32) ||
                     (req.word_index > eff_lim[NUM_W-1:6]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sieved    <= 1'b0;
      s1_valid  <= 1'b0;
      buf_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sieved    <= sieved_next;
      s1_valid  <= s1_valid_next;
      buf_valid <= buf_valid_next;
      if (s1_valid && s2_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sieve_lim <= sieve_lim_next;
    fill_w    <= fill_w_next;
    i_num     <= i_next;
    m_num     <= m_next;
    buf_word  <= buf_word_next;
    buf_idx   <= buf_idx_next;
    s1_status <= s1_status_next;
    s1_mask   <= s1_mask_next;
    if (s1_valid && s2_free) begin
      out_bits   <= mem_rdata & s1_mask;
      out_status <= s1_status;
    end
  end

  always_comb begin
    state_next     = state;
    sieved_next    = sieved;
    sieve_lim_next = sieve_lim;
    fill_w_next    = fill_w;
    i_next         = i_num;
    m_next         = m_num;
    buf_word_next  = buf_word;
    buf_idx_next   = buf_idx;
    buf_valid_next = buf_valid;
    s1_status_next = s1_status;
    s1_mask_next   = s1_mask;
    s1_valid_next  = s1_valid && !s2_free;
    mem_we         = 1'b0;
    mem_waddr      = fill_w;
    mem_wdata      = word_mask(fill_w, sieve_lim);
    mem_re         = 1'b0;
    mem_raddr      = req.word_index;

    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req.operation == OP_READ) begin
            mem_re        = !range_err;
            s1_valid_next = 1'b1;
            if (range_err) begin
              s1_status_next = STS_RANGE_ERR;
              s1_mask_next   = '0;
            end else begin
              s1_status_next = STS_READ_OK;
              s1_mask_next   = sieved ? word_mask(req.word_index, mask_lim) : '0;
            end
          end else begin
            sieved_next    = 1'b1;
            sieve_lim_next = eff_lim;
            fill_w_next    = '0;
            state_next     = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (go) begin
          mem_we = 1'b1;
          if (fill_w == sieve_lim[NUM_W-1:6]) begin
            i_next     = 9'd2;
            state_next = ST_CHECK_RD;
          end else begin
            fill_w_next = fill_w + WIDX_W'(1);
          end
        end
      end
      ST_CHECK_RD: begin
        if (go) begin
          if (i_sq > {2'b0, sieve_lim}) begin
            state_next = ST_DONE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = {{(WIDX_W-3){1'b0}}, i_num[8:6]};
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (go) begin
          if (mem_rdata[i_num[5:0]]) begin
            m_next         = {7'b0, i_num, 1'b0};
            buf_valid_next = 1'b0;
            state_next     = ST_CROSS;
          end else begin
            i_next     = i_num + 9'd1;
            state_next = ST_CHECK_RD;
          end
        end
      end
      ST_CROSS: begin
        if (go) begin
          mem_waddr = buf_idx;
          mem_wdata = buf_word;
          if (m_num > {1'b0, sieve_lim}) begin
            // multiples of i done: write back, move to next candidate
            mem_we         = buf_valid;
            buf_valid_next = 1'b0;
            i_next         = i_num + 9'd1;
            state_next     = ST_CHECK_RD;
          end else if (buf_valid && buf_idx == m_num[NUM_W-1:6]) begin
            buf_word_next = buf_word & ~(64'd1 << m_num[5:0]);
            m_next        = m_num + {8'b0, i_num};
          end else begin
            // new word: write back the old one, fetch the next
            mem_we     = buf_valid;
            mem_re     = 1'b1;
            mem_raddr  = m_num[NUM_W-1:6];
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (go) begin
          buf_word_next  = mem_rdata;
          buf_idx_next   = m_num[NUM_W-1:6];
          buf_valid_next = 1'b1;
          state_next     = ST_CROSS;
        end
      end
      ST_DONE: begin
        if (go) begin
          s1_valid_next  = 1'b1;
          s1_status_next = STS_SIEVE_DONE;
          s1_mask_next   = '0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.prime_bits = out_bits;
  assign rsp.status     = out_status;

endmodule

/* tb/psb_checker.sv */
// Checker for the prime sieve bitmap block: watches the channels, predicts and compares.
module psb_checker import psb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [NUM_W-1:0] cfg_wr_data,
  psb_req_if               req,
  psb_rsp_if               rsp,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] bits;
    status_t           status;
  } prime_rsp_t;

  logic [DATA_W-1:0] prime_map [PSB_WORD_COUNT];
  logic [NUM_W-1:0]  limit_reg;
  prime_rsp_t        expected_rsp_q [$];
  int                errs = 0;

  assign fail_count = errs;

  // Limit saturated at the largest number and at the bitmap size.
  function automatic int sieve_limit();
    int lim;
    begin
      lim = int'(limit_reg);
      if (lim > PSB_MAX_NUMBER) begin
        lim = PSB_MAX_NUMBER;
      end
      if (lim > PSB_WORD_COUNT * 64 - 1) begin
        lim = PSB_WORD_COUNT * 64 - 1;
      end
      return lim;
    end
  endfunction

  function automatic void cross_out(int lim);
    int w;
    int base;
    int i;
    int m;
    begin
      for (w = 0; w < PSB_WORD_COUNT; w++) begin
        base = w * 64;
        if (base > lim) begin
          prime_map[w] = '0;
        end else if (lim - base >= 63) begin
          prime_map[w] = '1;
        end else begin
          prime_map[w] = (64'd1 << (lim - base + 1)) - 64'd1;
        end
      end
      prime_map[0][1:0] = 2'b00;
      for (i = 2; i * i <= lim; i++) begin
        if (prime_map[i >> 6][i & 63]) begin
          for (m = 2 * i; m <= lim; m += i) begin
            prime_map[m >> 6][m & 63] = 1'b0;
          end
        end
      end
    end
  endfunction

  function automatic prime_rsp_t read_word(logic [WIDX_W-1:0] idx);
    prime_rsp_t        r;
    int                lim;
    int                base;
    logic [DATA_W-1:0] w;
    begin
      lim  = sieve_limit();
      base = int'(idx) * 64;
      if (int'(idx) >= PSB_WORD_COUNT || base > lim) begin
        r.bits   = '0;
        r.status = STS_RANGE_ERR;
      end else begin
        w = prime_map[idx];
        if (lim - base < 63) begin
          w &= (64'd1 << (lim - base + 1)) - 64'd1;
        end
        if (idx == '0) begin
          w[1:0] = 2'b00;
        end
        r.bits   = w;
        r.status = STS_READ_OK;
      end
      return r;
    end
  endfunction

  always @(posedge clk) begin
    prime_rsp_t want;
    int         w;
    if (rst) begin
      for (w = 0; w < PSB_WORD_COUNT; w++) begin
        prime_map[w] = '0;
      end
      limit_reg = NUM_W'(65535);
      expected_rsp_q.delete();
    end else begin
      if (cfg_wr_en) begin
        limit_reg = cfg_wr_data;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("unexpected response: bits=%h status=%0d", rsp.prime_bits, rsp.status);
          end
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.prime_bits !== want.bits || rsp.status !== want.status) begin
            errs++;
            if (errs <= 10) begin
              $display("mismatch: expected bits=%h status=%0d, got bits=%h status=%0d",
                       want.bits, want.status, rsp.prime_bits, rsp.status);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.operation == OP_SIEVE) begin
          cross_out(sieve_limit());
          want.bits   = '0;
          want.status = STS_SIEVE_DONE;
          expected_rsp_q.push_back(want);
        end else begin
          expected_rsp_q.push_back(read_word(req.word_index));
        end
      end
    end
    pending <= expected_rsp_q.size();
  end

endmodule

/* tb/tb_prime_sieve_bitmap.sv */
// Top of the prime sieve bitmap testbench: clock, reset, stimulus and verdict.
module tb_prime_sieve_bitmap import psb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Run stops here no matter what.
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_ITEMS = 1800;
  // Idle-mode switch points, counted in accepted requests.
  localparam int MODE2_AT     = 600;
  localparam int MODE3_AT     = 1200;
  localparam int HOLD_CYCLES  = 300;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [NUM_W-1:0] cfg_wr_data;

  int  fail_count;
  int  pending;
  int  items_sent = 0;
  int  cur_limit  = 65535;
  int  snd_idle_pct = 36;
  int  rcv_idle_pct = 51;
  int  cycle_cnt = 0;
  bit  pressure_on = 1'b0;

  psb_req_if req_ch ();
  psb_rsp_if rsp_ch ();

  prime_sieve_bitmap u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch.sink),
    .rsp         (rsp_ch.source)
  );

  psb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop: a lost response or a hung sieve ends up here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Response side. Ready toggles at the falling edge with the current idle
  // rate. Once pressure_on goes high the receiver holds off for a long
  // stretch, once, so the two-entry pipe fills and input ready drops.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_on && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // One request: optional idle gap, then hold valid until accepted. Valid is
  // left high on return; the next call or the drain decides what follows,
  // so valid is never lowered and raised in the same step.
  task automatic send_req(op_t op, logic [WIDX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.word_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    items_sent++;
    // Sender idles 36 / receiver 51, then swapped, then neither.
    if (items_sent < MODE2_AT) begin
      snd_idle_pct = 36;
      rcv_idle_pct = 51;
    end else if (items_sent < MODE3_AT) begin
      snd_idle_pct = 51;
      rcv_idle_pct = 36;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
  endtask

  // Drop valid and wait until every outstanding response is back, plus the
  // given slack, before touching the limit register.
  task automatic wait_idle(int slack);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (slack) @(posedge clk);
  endtask

  task automatic write_limit(int lim);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= NUM_W'(lim);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_limit = lim;
  endtask

  // Mostly words inside the limit, some just past it, some anywhere.
  function automatic logic [WIDX_W-1:0] pick_word(int lim);
    int top_w;
    int r;
    int hi;
    begin
      top_w = lim >> 6;
      r     = $urandom_range(0, 99);
      if (r < 70) begin
        return WIDX_W'($urandom_range(0, top_w));
      end else if (r < 85 && top_w < PSB_WORD_COUNT - 1) begin
        hi = (top_w + 2 > PSB_WORD_COUNT - 1) ? PSB_WORD_COUNT - 1 : top_w + 2;
        return WIDX_W'($urandom_range(top_w + 1, hi));
      end
      return WIDX_W'($urandom);
    end
  endfunction

  initial begin
    int  rand_goal;
    int  lim;
    int  pick;
    int  n_items;
    bit  can_sieve;
    bit  hold_phase;

    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_SIEVE;
    req_ch.word_index = '0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // Nothing sieved yet: words read as zero with read-ok status.
    send_req(OP_READ, 10'd0);
    send_req(OP_READ, 10'd1023);
    // Full sieve at the reset limit; the index on a sieve request is ignored.
    send_req(OP_SIEVE, 10'h3FF);
    send_req(OP_READ, 10'd0);
    send_req(OP_READ, 10'd1);
    send_req(OP_READ, 10'd511);
    send_req(OP_READ, 10'h2AA);
    send_req(OP_READ, 10'h155);
    send_req(OP_READ, 10'd1023);

    // Smallest legal limit: only bit 2 survives, word 1 is out of range.
    wait_idle(4);
    write_limit(2);
    send_req(OP_SIEVE, 10'd0);
    send_req(OP_READ, 10'd0);
    send_req(OP_READ, 10'd1);
    send_req(OP_READ, 10'd1023);

    // Limit raised without a new sieve: 3 was never marked, stays clear.
    wait_idle(4);
    write_limit(3);
    send_req(OP_READ, 10'd0);
    send_req(OP_SIEVE, 10'd0);
    send_req(OP_READ, 10'd0);

    // Limit below two: the sieve leaves nothing set.
    wait_idle(4);
    write_limit(1);
    send_req(OP_SIEVE, 10'd0);
    send_req(OP_READ, 10'd0);

    // Limit exactly on a word boundary: word 1 holds only 64.
    wait_idle(4);
    write_limit(64);
    send_req(OP_SIEVE, 10'd0);
    send_req(OP_READ, 10'd0);
    send_req(OP_READ, 10'd1);
    send_req(OP_READ, 10'd2);

    // Top limit over a small sieve: high words read zero.
    wait_idle(4);
    write_limit(65535);
    send_req(OP_READ, 10'd1023);
    send_req(OP_READ, 10'd0);

    // --- random part, one limit setting per phase ---
    rand_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < rand_goal) begin
      wait_idle(4);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        lim = 2;
      end else if (pick < 10) begin
        lim = 65535;
      end else if (pick < 15) begin
        lim = $urandom_range(4096, 65534);
      end else if (pick < 85) begin
        lim = $urandom_range(2, 1023);
      end else begin
        lim = $urandom_range(1024, 4095);
      end
      // Large-limit sieves are slow; those phases only read.
      can_sieve  = (lim <= 4095);
      hold_phase = (items_sent >= MODE3_AT) && !pressure_on;
      write_limit(lim);
      if (hold_phase) begin
        // Reads only, no idling, receiver holds off: input must stall.
        pressure_on <= 1'b1;
        n_items = 40;
      end else begin
        n_items = $urandom_range(10, 50);
        if (can_sieve && $urandom_range(0, 99) < 80) begin
          send_req(OP_SIEVE, WIDX_W'($urandom));
        end
      end
      repeat (n_items) begin
        if (!hold_phase && can_sieve && $urandom_range(0, 99) < 2) begin
          send_req(OP_SIEVE, WIDX_W'($urandom));
        end else begin
          send_req(OP_READ, pick_word(cur_limit));
        end
      end
    end

    wait_idle(10);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
